// ----- src/u16u8_pkg.sv -----
package u16u8_pkg;

	// Default number of entries in the job queue between front and back.
	localparam int unsigned QueueDepth = 4;

	// Surrogate markers: the upper six bits of a UTF-16 unit.
	localparam logic [5:0] SurrHighTag = 6'b110110;
	localparam logic [5:0] SurrLowTag  = 6'b110111;

	// Replacement character U+FFFD and its UTF-8 bytes.
	localparam logic [20:0] ReplacementCp = 21'h00fffd;
	localparam logic [7:0]  RepByte0      = 8'hef;
	localparam logic [7:0]  RepByte1      = 8'hbf;
	localparam logic [7:0]  RepByte2      = 8'hbd;

	// Offset of supplementary code points above the ten high-surrogate bits.
	localparam logic [10:0] SuppBaseHigh = 11'd64;

	// Lead and continuation byte prefixes.
	localparam logic [7:0] Lead2Prefix = 8'hc0;
	localparam logic [7:0] Lead3Prefix = 8'he0;
	localparam logic [7:0] Lead4Prefix = 8'hf0;
	localparam logic [7:0] ContPrefix  = 8'h80;

	// One encoded code point: up to four bytes, first byte in entry 0.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      nbytes;
	} enc_t;

	// One queued job: up to six bytes caused by one input word.
	typedef struct packed {
		logic [5:0][7:0] bytes;
		logic [2:0]      nbytes;
	} job_t;

	// UTF-8 encoding of one code point.
	function automatic enc_t encode_cp(input logic [20:0] cp);
		enc_t e;
		e.bytes = '0;
		if (cp[20:7] == '0) begin
			e.bytes[0] = {1'b0, cp[6:0]};
			e.nbytes   = 3'd1;
		end else if (cp[20:11] == '0) begin
			e.bytes[0] = Lead2Prefix | {3'b000, cp[10:6]};
			e.bytes[1] = ContPrefix | {2'b00, cp[5:0]};
			e.nbytes   = 3'd2;
		end else if (cp[20:16] == '0) begin
			e.bytes[0] = Lead3Prefix | {4'b0000, cp[15:12]};
			e.bytes[1] = ContPrefix | {2'b00, cp[11:6]};
			e.bytes[2] = ContPrefix | {2'b00, cp[5:0]};
			e.nbytes   = 3'd3;
		end else begin
			e.bytes[0] = Lead4Prefix | {5'b00000, cp[20:18]};
			e.bytes[1] = ContPrefix | {2'b00, cp[17:12]};
			e.bytes[2] = ContPrefix | {2'b00, cp[11:6]};
			e.bytes[3] = ContPrefix | {2'b00, cp[5:0]};
			e.nbytes   = 3'd4;
		end
		return e;
	endfunction

endpackage

// ----- src/utf16_to_utf8_transcoder.sv -----
// UTF-16 to UTF-8 transcoder.
// The slave channel takes one UTF-16 code unit per word in s_tdata, with
// s_tlast marking the final unit of a string. The master channel sends one
// UTF-8 byte per word in m_tdata; m_tlast marks the last byte caused by an
// input word. A high surrogate is held until the next unit and sends nothing
// on its own; unpaired surrogates become U+FFFD (EF BF BD).
// The front classifies each unit and pushes a job of up to six bytes into a
// queue of QueueDepth jobs; the back sends one byte per cycle from the head
// while the receiver is ready. When the queue was empty, the first byte of an
// input word passes through the queue and then the output register.
// Throughput: one input word per cycle while the queue has room; the master
// side sends one byte per cycle while the receiver is ready, so the sustained
// input rate is bounded by the byte count of the words (1 to 6 per job).
// Reset empties the queue, clears the output valid flag and any held surrogate.
// When the receiver stalls, the output byte holds and the queue fills;
// s_tready drops only when the queue is full.
module utf16_to_utf8_transcoder #(
	parameter int unsigned QueueDepth = u16u8_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // code_unit
	input  logic        s_tlast,   // last_unit
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte
	output logic        m_tlast    // run_end
);
	import u16u8_pkg::*;

	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	job_t push_job;
	job_t head;

	// Front: surrogate pairing and encoding.
	u16u8_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	// Job queue between the two halves.
	u16u8_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	// Back: byte serializer and output register.
	u16u8_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ----- src/u16u8_front.sv -----
module u16u8_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // code_unit
	input  logic              s_tlast,   // last_unit
	input  logic              q_full,
	output logic              push,
	output u16u8_pkg::job_t   push_job
);
	import u16u8_pkg::*;

	logic [9:0]  held_high_q;
	logic        have_high_q;
	logic        is_high;
	logic        is_low;
	logic        pair;
	logic        rep_pre;
	logic        has_cp;
	logic        hold_next;
	logic [20:0] cp;
	enc_t        enc;
	logic        accept;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// Classify the incoming word against the surrogate ranges.
	assign is_high   = (s_tdata[15:10] == SurrHighTag);
	assign is_low    = (s_tdata[15:10] == SurrLowTag);
	assign pair      = have_high_q && is_low;
	assign rep_pre   = have_high_q && !is_low;
	assign hold_next = !pair && is_high && !s_tlast;

	// Pick the code point this word completes, if any.
	always_comb begin
		cp     = ReplacementCp;
		has_cp = 1'b1;
		if (pair) begin
			cp = {{1'b0, held_high_q} + SuppBaseHigh, s_tdata[9:0]};
		end else if (is_high) begin
			has_cp = s_tlast;
		end else if (!is_low) begin
			cp = {5'b00000, s_tdata};
		end
	end

	assign enc = encode_cp(cp);

	// Build the byte list: an optional replacement for a stranded high
	// surrogate, then the bytes of the current code point.
	always_comb begin
		push_job = '0;
		if (rep_pre) begin
			push_job.bytes[0] = RepByte0;
			push_job.bytes[1] = RepByte1;
			push_job.bytes[2] = RepByte2;
			if (has_cp) begin
				push_job.bytes[3] = enc.bytes[0];
				push_job.bytes[4] = enc.bytes[1];
				push_job.bytes[5] = enc.bytes[2];
				push_job.nbytes   = enc.nbytes + 3'd3;
			end else begin
				push_job.nbytes = 3'd3;
			end
		end else if (has_cp) begin
			push_job.bytes[3:0] = enc.bytes;
			push_job.nbytes     = enc.nbytes;
		end
	end

	// A held high surrogate with nothing else to send makes no job.
	assign push = accept && (push_job.nbytes != 3'd0);

	// Surrogate hold state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_high_q <= 1'b0;
			held_high_q <= '0;
		end else if (accept) begin
			have_high_q <= hold_next;
			held_high_q <= hold_next ? s_tdata[9:0] : 10'd0;
		end
	end

endmodule

// ----- src/u16u8_queue.sv -----
module u16u8_queue #(
	parameter int unsigned Depth = u16u8_pkg::QueueDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  u16u8_pkg::job_t   push_job,
	input  logic              pop,
	output logic              full,
	output logic              empty,
	output u16u8_pkg::job_t   head
);
	import u16u8_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign full  = (cnt_q == FullCnt);
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Job storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

endmodule

// ----- src/u16u8_back.sv -----
module u16u8_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  u16u8_pkg::job_t   head,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // out_byte
	output logic              m_tlast    // run_end
);
	import u16u8_pkg::*;

	logic [2:0] idx_q;
	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic       m_tlast_q;
	logic       load;
	logic       last_byte;
	logic [7:0] cur_byte;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// Walk the head job one byte at a time into the output register.
	assign cur_byte  = head.bytes[idx_q];
	assign last_byte = (idx_q == head.nbytes - 3'd1);
	assign load      = !empty && (!m_tvalid_q || m_tready);
	assign pop       = load && last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else if (load) begin
			m_tvalid_q <= 1'b1;
			idx_q      <= last_byte ? 3'd0 : idx_q + 3'd1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= cur_byte;
			m_tlast_q <= last_byte;
		end
	end

endmodule
